### rtl/arp_pkg.sv
// Package for the monophonic note arpeggiator: pattern entry type, register
// and mode codes, sequencer states, reset values and the LFSR step function.
// No dependencies; every module in rtl/ imports it.
package arp_pkg;

  localparam int unsigned MAX_STEPS_DEF    = 16;
  localparam int unsigned RANDOM_TRIES_DEF = 8;

  localparam int unsigned NOTE_W  = 8;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned LFSR_W  = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  localparam logic [15:0] TEMPO_RESET   = 16'd500;
  localparam logic [7:0]  SUSTAIN_RESET = 8'd128;
  localparam logic [4:0]  LENGTH_RESET  = 5'd1;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_SEQ    = 2'd1,
    MODE_RANDOM = 2'd2
  } arp_mode_e;

  localparam logic [1:0] MODE_RESET = MODE_SEQ;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMPO   = 2'd0,
    REG_SUSTAIN = 2'd1,
    REG_MODE    = 2'd2,
    REG_LENGTH  = 2'd3
  } arp_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CTRL,
    S_P_CUR,
    S_P_LATCH,
    S_R_DRAW,
    S_R_WAIT,
    S_R_READ,
    S_R_CMP,
    S_T_RD0,
    S_T_RD1,
    S_T_DIFF,
    S_T_MUL1,
    S_T_MUL2,
    S_T_UPD,
    S_RES,
    S_OUT
  } arp_state_e;

  typedef struct packed {
    logic signed [7:0]   offset;
    logic                silent;
    logic [TIME_W-1:0]   start_time;
  } arp_entry_t;

  // Galois step: shift right, fold the taps in when a one falls out.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

### rtl/arp_store.sv
// Pattern memory of the arpeggiator: one write port, one registered read port.
// Depends on arp_pkg for the entry type.
module arp_store #(
  parameter int unsigned DEPTH = arp_pkg::MAX_STEPS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  arp_pkg::arp_entry_t wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output arp_pkg::arp_entry_t rdata_o
);
  import arp_pkg::*;

  arp_entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/arp_rem.sv
// Iterative remainder unit: restoring division, one dividend bit per cycle.
// Depends on arp_pkg for the dividend width.
module arp_rem #(
  parameter int unsigned DW = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [arp_pkg::LFSR_W-1:0] dividend_i,
  input  logic [DW-1:0]             divisor_i,
  output logic                      done_o,
  output logic [DW-1:0]             rem_o
);
  import arp_pkg::*;

  localparam int unsigned CW = $clog2(LFSR_W);
  localparam logic [CW-1:0] CNT_LAST = CW'(LFSR_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [LFSR_W-1:0] dvd_q;
  logic [DW-1:0]     div_q;
  logic [DW-1:0]     rem_q;
  logic [DW:0]       sh;
  logic [DW:0]       sub;
  logic [DW-1:0]     rem_step;

  always_comb begin
    sh       = {rem_q, dvd_q[LFSR_W-1]};
    sub      = sh - {1'b0, div_q};
    rem_step = (sh >= {1'b0, div_q}) ? sub[DW-1:0] : sh[DW-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_step;
      dvd_q <= dvd_q << 1;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("remainder unit did not start");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("remainder done while still busy");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (div_q != '0) |-> rem_q < div_q) else $error("remainder out of range");

endmodule

### rtl/note_arpeggiator.sv
// Monophonic arpeggiator, one transaction per millisecond tick or pattern write.
// A tick that plays no event goes from decode straight to the result; a tick
// that plays an event also reads the pattern memory over its single read port
// and runs two registered multiplies. In random mode each draw also runs the
// bit-serial remainder unit, up to RANDOM_TRIES draws per event.
// The input side is ready only while no transaction is in progress.
// Depends on arp_pkg, arp_store and arp_rem.
module note_arpeggiator #(
  parameter int unsigned MAX_STEPS    = arp_pkg::MAX_STEPS_DEF,
  parameter int unsigned RANDOM_TRIES = arp_pkg::RANDOM_TRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // button_pressed, button_released, trigger_active, held_note[7:0],
  // entry_index[3:0], entry_offset[7:0], entry_silent, entry_time[15:0]
  input  logic [arp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // op
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // note_out[7:0], running, is_armed, zero padding
  output logic [arp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [arp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [arp_pkg::CFG_W-1:0]       cfg_data_i
);
  import arp_pkg::*;

  localparam int unsigned SW = $clog2(MAX_STEPS);
  localparam int unsigned LW = $clog2(MAX_STEPS + 1);
  localparam int unsigned TW = $clog2(RANDOM_TRIES + 1);

  arp_state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] tempo_q;
  logic [7:0]  sustain_q;
  logic [1:0]  mode_q;
  logic [4:0]  plen_q;

  // Architectural state.
  logic              armed_q, armed_d;
  logic              started_q, started_d;
  logic [NOTE_W-1:0] last_q, last_d;
  logic [SW-1:0]     step_q, step_d;
  logic [31:0]       now_q, now_d;
  logic [31:0]       event_due_q, event_due_d;
  logic [31:0]       silence_due_q, silence_due_d;
  logic [LFSR_W-1:0] lfsr_q, lfsr_d;
  logic              snd_valid_q, snd_valid_d;
  logic              snd_rest_q, snd_rest_d;
  logic signed [7:0] snd_off_q, snd_off_d;

  // Latched transaction fields.
  logic              op_q;
  logic              pressed_q, released_q, trig_q;
  logic [NOTE_W-1:0] held_q;
  logic [3:0]        eidx_q;
  arp_entry_t        entry_q;

  // Working registers of the sequencer.
  logic [LW-1:0]     cur_q, cur_d;
  logic [LW-1:0]     cand_q, cand_d;
  logic [LW-1:0]     nxt_q, nxt_d;
  logic [TW-1:0]     tries_q, tries_d;
  logic [TIME_W-1:0] a_time_q, a_time_d;
  logic [16:0]       d_q, d_d;
  logic [32:0]       ms_q, ms_d;
  logic [40:0]       sc_q, sc_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic [NOTE_W-1:0] out_note_q, out_note_d;
  logic              out_run_q, out_run_d;
  logic              out_arm_q, out_arm_d;

  // Memory and remainder unit hookup.
  logic              mem_we;
  logic              wr_ok;
  logic [SW-1:0]     rd_addr;
  arp_entry_t        rd_entry;
  logic              rem_start;
  logic              rem_done;
  logic [LW-1:0]     rem_res;
  logic [LFSR_W-1:0] lfsr_next_w;

  logic              in_acc;
  logic [LW-1:0]     len_w;
  logic [LW-1:0]     cur_w;
  logic [LW-1:0]     inc_w;
  logic [LW-1:0]     seq_inc_w;
  logic              tries_done_w;
  logic              cand_hit_w;
  logic              same_w;
  logic              sil_hit_w;

  // Tick control decisions.
  logic              ctl_a, ctl_s, ctl_v, ctl_rs, ctl_play;
  logic [NOTE_W-1:0] ctl_last;
  logic [31:0]       ctl_due;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - NOTE_W - 2){1'b0}}, out_arm_q, out_run_q,
                          out_note_q};

  // A length of zero plays one entry; a length past the store plays all of it.
  always_comb begin
    if (plen_q == '0) begin
      len_w = LW'(1);
    end else if (int'(plen_q) > MAX_STEPS) begin
      len_w = LW'(MAX_STEPS);
    end else begin
      len_w = LW'(plen_q);
    end
  end

  assign cur_w        = (LW'(step_q) >= len_w) ? '0 : LW'(step_q);
  assign inc_w        = cur_q + LW'(1);
  assign seq_inc_w    = (inc_w >= len_w) ? '0 : inc_w;
  assign tries_done_w = (tries_q == TW'(RANDOM_TRIES));
  assign cand_hit_w   = (rem_res == cur_q);
  assign sil_hit_w    = (now_q >= silence_due_q);
  assign lfsr_next_w  = lfsr_step(lfsr_q);
  assign wr_ok        = (int'(eidx_q) < MAX_STEPS);
  assign same_w       = (rd_entry.silent || snd_rest_q) ? (rd_entry.silent && snd_rest_q)
                                                        : (rd_entry.offset == snd_off_q);

  // Button, trigger and note-change handling of a tick.
  always_comb begin
    ctl_a    = armed_q | pressed_q;
    ctl_s    = started_q;
    ctl_v    = snd_valid_q;
    ctl_rs   = 1'b0;
    ctl_last = last_q;
    if (released_q) begin
      ctl_a = 1'b0;
      ctl_s = 1'b0;
      ctl_v = 1'b0;
    end
    if (ctl_a && trig_q && !ctl_s) begin
      ctl_rs = 1'b1;
      ctl_s  = 1'b1;
      ctl_v  = 1'b0;
    end
    if (!trig_q) begin
      ctl_a = 1'b0;
      ctl_s = 1'b0;
      ctl_v = 1'b0;
    end
    if (ctl_s) begin
      if (held_q != '0) begin
        if (held_q != ctl_last) begin
          ctl_last = held_q;
          ctl_rs   = 1'b1;
          ctl_v    = 1'b0;
        end
      end else begin
        ctl_last = '0;
      end
    end
    ctl_due  = ctl_rs ? now_q : event_due_q;
    ctl_play = ctl_s && (held_q != '0) && (now_q >= ctl_due);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_acc) state_d = S_CTRL;
      S_CTRL: begin
        if (op_q == OP_WRITE) begin
          state_d = S_RES;
        end else begin
          state_d = ctl_play ? S_P_CUR : S_RES;
        end
      end
      S_P_CUR:   state_d = S_P_LATCH;
      S_P_LATCH: state_d = (mode_q == MODE_RANDOM) ? S_R_DRAW : S_T_RD0;
      S_R_DRAW:  state_d = tries_done_w ? S_T_RD0 : S_R_WAIT;
      S_R_WAIT: begin
        if (rem_done) begin
          state_d = cand_hit_w ? S_R_DRAW : S_R_READ;
        end
      end
      S_R_READ:  state_d = S_R_CMP;
      S_R_CMP:   state_d = same_w ? S_R_DRAW : S_T_RD0;
      S_T_RD0:   state_d = S_T_RD1;
      S_T_RD1:   state_d = S_T_DIFF;
      S_T_DIFF:  state_d = S_T_MUL1;
      S_T_MUL1:  state_d = S_T_MUL2;
      S_T_MUL2:  state_d = S_T_UPD;
      S_T_UPD:   state_d = S_RES;
      S_RES:     state_d = S_OUT;
      S_OUT:     if (m_axis_tready) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs of each state.
  always_comb begin
    armed_d       = armed_q;
    started_d     = started_q;
    last_d        = last_q;
    step_d        = step_q;
    now_d         = now_q;
    event_due_d   = event_due_q;
    silence_due_d = silence_due_q;
    lfsr_d        = lfsr_q;
    snd_valid_d   = snd_valid_q;
    snd_rest_d    = snd_rest_q;
    snd_off_d     = snd_off_q;
    cur_d         = cur_q;
    cand_d        = cand_q;
    nxt_d         = nxt_q;
    tries_d       = tries_q;
    a_time_d      = a_time_q;
    d_d           = d_q;
    ms_d          = ms_q;
    sc_d          = sc_q;
    out_valid_d   = out_valid_q;
    out_note_d    = out_note_q;
    out_run_d     = out_run_q;
    out_arm_d     = out_arm_q;
    mem_we        = 1'b0;
    rd_addr       = '0;
    rem_start     = 1'b0;
    unique case (state_q)
      S_CTRL: begin
        if (op_q == OP_WRITE) begin
          mem_we = wr_ok;
        end else begin
          armed_d     = ctl_a;
          started_d   = ctl_s;
          snd_valid_d = ctl_v;
          last_d      = ctl_last;
          if (ctl_rs) begin
            step_d      = '0;
            event_due_d = now_q;
          end
        end
      end
      S_P_CUR: begin
        rd_addr = SW'(cur_w);
        cur_d   = cur_w;
      end
      S_P_LATCH: begin
        snd_valid_d = 1'b1;
        snd_rest_d  = rd_entry.silent;
        snd_off_d   = rd_entry.offset;
        tries_d     = '0;
        nxt_d       = (mode_q == MODE_SEQ) ? seq_inc_w : cur_q;
      end
      S_R_DRAW: begin
        if (tries_done_w) begin
          nxt_d = seq_inc_w;
        end else begin
          lfsr_d    = lfsr_next_w;
          rem_start = 1'b1;
          tries_d   = tries_q + TW'(1);
        end
      end
      S_R_WAIT: begin
        if (rem_done) begin
          cand_d = rem_res;
        end
      end
      S_R_READ: rd_addr = SW'(cand_q);
      S_R_CMP: begin
        if (!same_w) begin
          nxt_d = cand_q;
        end
      end
      S_T_RD0: begin
        rd_addr = (nxt_q == '0) ? SW'(len_w - LW'(1)) : SW'(nxt_q);
      end
      S_T_RD1: begin
        a_time_d = rd_entry.start_time;
        rd_addr  = (nxt_q == '0) ? '0 : SW'(nxt_q - LW'(1));
      end
      S_T_DIFF: begin
        // Wrapping to the first entry: the cycle ends at the next whole unit
        // after the last entry's start time.
        if (nxt_q == '0) begin
          d_d = 17'(9'd256 - {1'b0, a_time_q[7:0]}) + {1'b0, rd_entry.start_time};
        end else if (a_time_q >= rd_entry.start_time) begin
          d_d = {1'b0, a_time_q - rd_entry.start_time};
        end else begin
          d_d = '0;
        end
      end
      S_T_MUL1: ms_d = {17'd0, tempo_q} * {16'd0, d_q};
      S_T_MUL2: sc_d = {8'd0, ms_q} * {33'd0, sustain_q};
      S_T_UPD: begin
        silence_due_d = event_due_q + {6'd0, sc_q[40:15]};
        event_due_d   = event_due_q + {7'd0, ms_q[32:8]};
        step_d        = SW'(nxt_q);
      end
      S_RES: begin
        out_valid_d = 1'b1;
        out_run_d   = started_q;
        out_arm_d   = armed_q;
        if (op_q == OP_WRITE) begin
          out_note_d = '0;
        end else begin
          now_d = now_q + 32'd1;
          if (!started_q) begin
            out_note_d = held_q;
          end else if (held_q == '0) begin
            out_note_d = '0;
          end else begin
            if (sil_hit_w) begin
              snd_valid_d = 1'b0;
            end
            out_note_d = (snd_valid_q && !sil_hit_w && !snd_rest_q)
                       ? held_q + NOTE_W'(snd_off_q) : '0;
          end
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      tempo_q       <= TEMPO_RESET;
      sustain_q     <= SUSTAIN_RESET;
      mode_q        <= MODE_RESET;
      plen_q        <= LENGTH_RESET;
      armed_q       <= 1'b0;
      started_q     <= 1'b0;
      last_q        <= '0;
      step_q        <= '0;
      now_q         <= '0;
      event_due_q   <= '0;
      silence_due_q <= '0;
      lfsr_q        <= LFSR_SEED;
      snd_valid_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      armed_q       <= armed_d;
      started_q     <= started_d;
      last_q        <= last_d;
      step_q        <= step_d;
      now_q         <= now_d;
      event_due_q   <= event_due_d;
      silence_due_q <= silence_due_d;
      lfsr_q        <= lfsr_d;
      snd_valid_q   <= snd_valid_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        unique case (arp_reg_e'(cfg_idx_i))
          REG_TEMPO:   tempo_q   <= cfg_data_i[15:0];
          REG_SUSTAIN: sustain_q <= cfg_data_i[7:0];
          REG_MODE:    mode_q    <= cfg_data_i[1:0];
          REG_LENGTH:  plen_q    <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q             <= s_axis_tuser;
      pressed_q        <= s_axis_tdata[0];
      released_q       <= s_axis_tdata[1];
      trig_q           <= s_axis_tdata[2];
      held_q           <= s_axis_tdata[10:3];
      eidx_q           <= s_axis_tdata[14:11];
      entry_q.offset   <= s_axis_tdata[22:15];
      entry_q.silent   <= s_axis_tdata[23];
      entry_q.start_time <= s_axis_tdata[39:24];
    end
    snd_rest_q <= snd_rest_d;
    snd_off_q  <= snd_off_d;
    cur_q      <= cur_d;
    cand_q     <= cand_d;
    nxt_q      <= nxt_d;
    tries_q    <= tries_d;
    a_time_q   <= a_time_d;
    d_q        <= d_d;
    ms_q       <= ms_d;
    sc_q       <= sc_d;
    out_note_q <= out_note_d;
    out_run_q  <= out_run_d;
    out_arm_q  <= out_arm_d;
  end

  arp_store #(
    .DEPTH (MAX_STEPS),
    .AW    (SW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (SW'(eidx_q)),
    .wdata_i (entry_q),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  arp_rem #(
    .DW (LW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (lfsr_next_w),
    .divisor_i  (len_w),
    .done_o     (rem_done),
    .rem_o      (rem_res)
  );

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while a result is pending");
  a_accept_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_CTRL) else $error("accepted transaction not decoded");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_T_UPD) && !cfg_we_i |=> LW'(step_q) < len_w)
    else $error("step index past pattern length");
  a_rem_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> state_q == S_R_WAIT) else $error("remainder finished outside a draw");

endmodule

### dv/note_arpeggiator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for note_arpeggiator: random and directed ticks and pattern
// writes over stream ports, results predicted by a scoreboard class.
// Depends on arp_pkg and the note_arpeggiator RTL.
module note_arpeggiator_test;
  import arp_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int PHASES        = 18;
  localparam int PHASE_ITEMS   = 57;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_AT       = 300;
  localparam int LONG_HOLD     = 400;

  // Input item, lowest bit first: button_pressed .. entry_time.
  typedef struct packed {
    logic [15:0]       entry_time;
    logic              entry_silent;
    logic signed [7:0] entry_offset;
    logic [3:0]        entry_index;
    logic [7:0]        held_note;
    logic              trigger_active;
    logic              button_released;
    logic              button_pressed;
  } arp_in_t;

  typedef struct packed {
    logic [5:0] pad;
    logic       is_armed;
    logic       running;
    logic [7:0] note_out;
  } arp_result_t;

  class arp_scoreboard;
    logic [15:0]       tempo;
    logic [7:0]        sustain;
    logic [1:0]        mode;
    logic [4:0]        length;
    logic signed [7:0] offs   [MAX_STEPS_DEF];
    logic              rests  [MAX_STEPS_DEF];
    logic [15:0]       starts [MAX_STEPS_DEF];
    logic              armed, started, snd_valid, snd_rest;
    logic signed [7:0] snd_off;
    logic [7:0]        base_note;
    int unsigned       cursor;
    logic [31:0]       now_ms, event_due, silence_due;
    logic [15:0]       lfsr;
    arp_result_t       due_results [$];
    int                errors;

    function new();
      tempo = TEMPO_RESET;
      sustain = SUSTAIN_RESET;
      mode = MODE_SEQ;
      length = LENGTH_RESET;
      foreach (offs[i]) begin
        offs[i] = '0;
        rests[i] = 1'b0;
        starts[i] = '0;
      end
      armed = 1'b0;
      started = 1'b0;
      snd_valid = 1'b0;
      snd_rest = 1'b0;
      snd_off = '0;
      base_note = '0;
      cursor = 0;
      now_ms = '0;
      event_due = '0;
      silence_due = '0;
      lfsr = LFSR_SEED;
      errors = 0;
    endfunction

    function void set_reg(arp_reg_e r, logic [15:0] v);
      case (r)
        REG_TEMPO:   tempo = v;
        REG_SUSTAIN: sustain = v[7:0];
        REG_MODE:    mode = v[1:0];
        REG_LENGTH:  length = v[4:0];
        default: ;
      endcase
    endfunction

    function int unsigned used_len();
      if (length < 1) return 1;
      if (length > MAX_STEPS_DEF) return MAX_STEPS_DEF;
      return length;
    endfunction

    function int unsigned draw();
      logic lsb;
      lsb = lfsr[0];
      lfsr = lfsr >> 1;
      if (lsb) lfsr = lfsr ^ LFSR_TAPS;
      return lfsr;
    endfunction

    // Two rests match each other; a rest never matches a sounding entry.
    function bit same_entry(int unsigned a, int unsigned b);
      if (rests[a] || rests[b]) return rests[a] && rests[b];
      return offs[a] == offs[b];
    endfunction

    function void start_arp();
      cursor = 0;
      event_due = now_ms;
      started = 1'b1;
      snd_valid = 1'b0;
    endfunction

    function void stop_arp();
      armed = 1'b0;
      started = 1'b0;
      snd_valid = 1'b0;
    endfunction

    function void play_step();
      int unsigned n, cur, c;
      int          tries;
      bit          found;
      longint      d, lt, ms;
      n = used_len();
      if (cursor >= n) cursor = 0;
      cur = cursor;
      snd_valid = 1'b1;
      snd_rest = rests[cur];
      snd_off = offs[cur];
      if (mode == MODE_SEQ) begin
        cursor = cur + 1;
      end else if (mode == MODE_RANDOM) begin
        found = 0;
        tries = 0;
        while (tries < RANDOM_TRIES_DEF && !found) begin
          c = draw() % n;
          if (c != cur && !same_entry(c, cur)) begin
            cursor = c;
            found = 1;
          end
          tries++;
        end
        if (!found) cursor = cur + 1;
      end
      if (cursor >= n) cursor = 0;
      // Wrapping back to the first entry rounds the last start up to a whole unit.
      if (cursor == 0) begin
        lt = longint'(starts[n-1]);
        d = ((lt >> 8) + 1) * 256 + longint'(starts[0]) - lt;
      end else begin
        d = longint'(starts[cursor]) - longint'(starts[cursor-1]);
      end
      if (d < 0) d = 0;
      ms = longint'(tempo) * d;
      silence_due = event_due + 32'((ms * longint'(sustain)) >> 15);
      event_due = event_due + 32'(ms >> 8);
    endfunction

    function void take_input(logic op, arp_in_t f);
      arp_result_t r;
      r = '0;
      if (op == OP_WRITE) begin
        offs[f.entry_index] = f.entry_offset;
        rests[f.entry_index] = f.entry_silent;
        starts[f.entry_index] = f.entry_time;
      end else begin
        if (f.button_pressed) armed = 1'b1;
        if (f.button_released) stop_arp();
        if (armed && f.trigger_active && !started) start_arp();
        if (!f.trigger_active) stop_arp();
        r.note_out = f.held_note;
        if (started) begin
          if (f.held_note != 0) begin
            if (f.held_note != base_note) begin
              base_note = f.held_note;
              start_arp();
            end
            if (now_ms >= event_due) play_step();
            if (now_ms >= silence_due) snd_valid = 1'b0;
            if (snd_valid && !snd_rest) r.note_out = f.held_note + snd_off;
            else r.note_out = '0;
          end else begin
            base_note = '0;
            r.note_out = '0;
          end
        end
        now_ms = now_ms + 1;
      end
      r.running = started;
      r.is_armed = armed;
      due_results.push_back(r);
    endfunction

    function void take_result(logic [15:0] raw);
      arp_result_t got, want;
      got = raw;
      if (due_results.size() == 0) begin
        $error("result with nothing expected: tdata %h", raw);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.note_out !== want.note_out) begin
        $error("note_out: expected %0d, got %0d", want.note_out, got.note_out);
        errors++;
      end
      if (got.running !== want.running) begin
        $error("running: expected %0b, got %0b", want.running, got.running);
        errors++;
      end
      if (got.is_armed !== want.is_armed) begin
        $error("is_armed: expected %0b, got %0b", want.is_armed, got.is_armed);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;

  arp_scoreboard book;
  bit            calm;
  bit            trig_level;
  logic [7:0]    played_note;

  note_arpeggiator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Mostly back to back, sometimes a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic arp_in_t rand_item();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[IN_TDATA_W-1:0];
  endfunction

  task automatic offer(input logic op, input arp_in_t f);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    book.take_input(op, f);
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input arp_reg_e r, input logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    book.set_reg(r, v);
  endtask

  task automatic write_regs(input logic [15:0] tempo_v, input logic [7:0] sus_v,
                            input logic [1:0] mode_v, input logic [4:0] len_v);
    put_reg(REG_TEMPO, tempo_v);
    put_reg(REG_SUSTAIN, 16'(sus_v));
    put_reg(REG_MODE, 16'(mode_v));
    put_reg(REG_LENGTH, 16'(len_v));
    cfg_we_i <= 1'b0;
  endtask

  task automatic tick(input bit pressed, input bit released, input bit trig,
                      input logic [7:0] held);
    arp_in_t f;
    f = '0;
    f.button_pressed = pressed;
    f.button_released = released;
    f.trigger_active = trig;
    f.held_note = held;
    offer(OP_TICK, f);
  endtask

  // Start times rise by a random stride so the pattern plays as intended.
  task automatic load_pattern(input int n, input bit narrow);
    arp_in_t     f;
    int unsigned t, stride;
    t = $urandom_range(0, 300);
    stride = $urandom_range(16, 512);
    for (int i = 0; i < n; i++) begin
      f = rand_item();
      f.entry_index = 4'(i);
      if (narrow) f.entry_offset = 8'($urandom_range(0, 1) * 12);
      f.entry_silent = ($urandom_range(0, 99) < 15);
      f.entry_time = 16'(t);
      t += $urandom_range(stride / 2, stride);
      offer(OP_WRITE, f);
    end
  endtask

  // A player holding the trigger and changing notes now and then, or a random tick when noisy.
  task automatic perform_tick(input bit noisy);
    arp_in_t f;
    f = rand_item();
    if (!noisy) begin
      f.button_pressed = ($urandom_range(0, 99) < 8);
      f.button_released = ($urandom_range(0, 99) < 2);
      if ($urandom_range(0, 99) < (trig_level ? 2 : 15)) trig_level = !trig_level;
      f.trigger_active = trig_level;
      if ($urandom_range(0, 99) < 4) begin
        played_note = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      end
      f.held_note = played_note;
    end
    offer(OP_TICK, f);
  endtask

  task automatic run_phase(input int p);
    logic [15:0] tempo_v;
    logic [7:0]  sus_v;
    logic [1:0]  mode_v;
    logic [4:0]  len_v;
    int          n, sent, r, noise_pct;
    tempo_v = (p == 2) ? 16'd0 : (p == 4) ? 16'hFFFF : (p == 7) ? 16'd1 :
              ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 2000)) :
              16'($urandom_range(1, 12));
    sus_v = (p == 1) ? 8'd0 : (p == 3) ? 8'hFF : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 9);
    case (p)
      0: mode_v = MODE_HOLD;
      1: mode_v = MODE_SPARE;
      2: mode_v = MODE_SEQ;
      3: mode_v = MODE_RANDOM;
      default: mode_v = (r < 4) ? MODE_RANDOM : (r < 7) ? MODE_SEQ :
                        (r < 9) ? MODE_HOLD : MODE_SPARE;
    endcase
    len_v = (p == 5) ? 5'd0 : (p == 6) ? 5'd31 : (p == 9) ? 5'd1 :
            (p == 3 || p == 8) ? 5'd16 :
            ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31)) :
            5'($urandom_range(1, 16));
    n = (len_v == 0) ? 1 : (len_v > MAX_STEPS_DEF) ? MAX_STEPS_DEF : len_v;
    noise_pct = (p % 4 == 3) ? 30 : 10;

    drain();
    calm = (p % 3 == 2);
    write_regs(tempo_v, sus_v, mode_v, len_v);
    sent = 0;
    if ($urandom_range(0, 3) != 0) begin
      load_pattern(n, $urandom_range(0, 3) == 0);
      sent = n;
    end
    while (sent < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 4) offer(OP_WRITE, rand_item());
      else perform_tick(r < 4 + noise_pct);
      sent++;
    end
  endtask

  initial begin : stimulus
    arp_in_t f;
    book = new();
    calm = 1'b0;
    trig_level = 1'b1;
    played_note = 8'd60;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_TICK;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_TEMPO;
    cfg_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every entry gets written first, so no tick can read an empty one.
    for (int i = 0; i < MAX_STEPS_DEF; i++) begin
      f = '0;
      f.entry_index = 4'(i);
      f.entry_offset = (i == 0) ? 8'sd127 : (i == 1) ? -8'sd128 : 8'(i * 3);
      f.entry_silent = (i == 2);
      f.entry_time = (i == 15) ? 16'hFFFF : 16'(i * 256);
      offer(OP_WRITE, f);
    end
    tick(1'b0, 1'b0, 1'b0, 8'd60);
    tick(1'b1, 1'b0, 1'b1, 8'd60);
    tick(1'b0, 1'b0, 1'b1, 8'd255);
    f = '0;
    f.entry_index = 4'd3;
    f.entry_time = 16'd768;
    offer(OP_WRITE, f);
    tick(1'b0, 1'b0, 1'b1, 8'd0);
    tick(1'b0, 1'b0, 1'b1, 8'd200);
    tick(1'b0, 1'b1, 1'b1, 8'd200);
    tick(1'b1, 1'b1, 1'b1, 8'd1);

    for (int p = 0; p < PHASES; p++) run_phase(p);
    drain();
    if (book.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin : result_sink
    int stall;
    int seen;
    bit held_off;
    stall = 0;
    seen = 0;
    held_off = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        book.take_result(m_axis_tdata);
        seen++;
        stall = pick_gap();
        // One long stall mid-run so the block backs up onto its input.
        if (seen == HOLD_AT && !held_off) begin
          stall = LONG_HOLD;
          held_off = 1;
        end
      end else if (stall == 0 && !calm && $urandom_range(0, 99) < 5) begin
        stall = $urandom_range(1, 6);
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### note_arpeggiator.f
rtl/arp_pkg.sv
rtl/arp_store.sv
rtl/arp_rem.sv
rtl/note_arpeggiator.sv
dv/note_arpeggiator_test.sv
